### rtl/hcap_pkg.sv
// Shared types, constants and helper functions for the hex color parser.
package hcap_pkg;

    localparam int unsigned STORE_DEPTH = 16;
    localparam int unsigned NIB_W       = 4;
    localparam int unsigned COUNT_W     = 5;
    localparam int unsigned ARGB_W      = 32;

    localparam logic [7:0]         HASH_CHAR    = 8'h23;
    localparam logic [7:0]         ALPHA_OPAQUE = 8'hff;
    localparam logic [COUNT_W-1:0] COUNT_SAT    = 5'd17;
    localparam logic [COUNT_W-1:0] COUNT_FULL   = 5'd16;

    // Digit counts that name a valid token format.
    localparam logic [COUNT_W-1:0] LEN_RGB3   = 5'd3;
    localparam logic [COUNT_W-1:0] LEN_ARGB4  = 5'd4;
    localparam logic [COUNT_W-1:0] LEN_RGB6   = 5'd6;
    localparam logic [COUNT_W-1:0] LEN_ARGB8  = 5'd8;
    localparam logic [COUNT_W-1:0] LEN_RGB9   = 5'd9;
    localparam logic [COUNT_W-1:0] LEN_RGB12  = 5'd12;
    localparam logic [COUNT_W-1:0] LEN_ARGB16 = 5'd16;

    typedef logic [STORE_DEPTH*NIB_W-1:0] nib_vec_t;

    // Token status handed from the digit store to the top level.
    typedef struct packed {
        logic                 term;
        logic [COUNT_W-1:0]   count;
    } hcap_tok_t;

    typedef struct packed {
        logic             is_hex;
        logic [NIB_W-1:0] value;
    } hcap_digit_t;

    function automatic hcap_digit_t classify(input logic [7:0] ch);
        hcap_digit_t r;
        logic [7:0]  diff;
        r    = '{is_hex: 1'b0, value: '0};
        diff = 8'h00;
        if (ch >= 8'h30 && ch <= 8'h39) begin
            diff = ch - 8'h30;
            r    = '{is_hex: 1'b1, value: diff[NIB_W-1:0]};
        end else if (ch >= 8'h61 && ch <= 8'h66) begin
            diff = ch - 8'h57;
            r    = '{is_hex: 1'b1, value: diff[NIB_W-1:0]};
        end else if (ch >= 8'h41 && ch <= 8'h46) begin
            diff = ch - 8'h37;
            r    = '{is_hex: 1'b1, value: diff[NIB_W-1:0]};
        end
        return r;
    endfunction

endpackage

### rtl/hcap_digit_store.sv
// Nibble store, digit counter and token-start flag of the hex color parser.
module hcap_digit_store (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   step,
    input  logic [7:0]             char_in,
    output hcap_pkg::hcap_tok_t    tok,
    output hcap_pkg::nib_vec_t     nibbles
);
    import hcap_pkg::*;

    logic [NIB_W-1:0]   store_reg [STORE_DEPTH];
    logic [COUNT_W-1:0] count_reg, count_next;
    logic               started_reg, started_next;
    hcap_digit_t        dig;
    logic               is_hash;
    logic               wr_en;

    always_comb begin
        dig     = classify(char_in);
        is_hash = !started_reg && (char_in == HASH_CHAR);
        wr_en   = step && !is_hash && dig.is_hex && (count_reg < COUNT_FULL);

        count_next   = count_reg;
        started_next = started_reg;
        if (step) begin
            if (is_hash) begin
                started_next = 1'b1;
            end else if (dig.is_hex) begin
                started_next = 1'b1;
                if (count_reg < COUNT_SAT) begin
                    count_next = count_reg + 5'd1;
                end
            end else begin
                count_next   = '0;
                started_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            started_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            started_reg <= started_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            store_reg[count_reg[NIB_W-1:0]] <= dig.value;
        end
    end

    always_comb begin
        for (int i = 0; i < STORE_DEPTH; i++) begin
            nibbles[i*NIB_W +: NIB_W] = store_reg[i];
        end
        tok.term  = !is_hash && !dig.is_hex;
        tok.count = count_reg;
    end

endmodule

### rtl/hcap_decode.sv
// Maps the digit count and stored nibbles to a packed ARGB word.
module hcap_decode (
    input  logic [hcap_pkg::COUNT_W-1:0] count,
    input  hcap_pkg::nib_vec_t           nibbles,
    output logic [hcap_pkg::ARGB_W-1:0]  argb,
    output logic                         format_ok
);
    import hcap_pkg::*;

    logic [NIB_W-1:0] n [STORE_DEPTH];

    always_comb begin
        for (int i = 0; i < STORE_DEPTH; i++) begin
            n[i] = nibbles[i*NIB_W +: NIB_W];
        end
    end

    // Each channel byte is two adjacent nibbles; short forms repeat one nibble.
    always_comb begin
        argb      = '0;
        format_ok = 1'b1;
        case (count)
            LEN_RGB3:   argb = {ALPHA_OPAQUE, n[0], n[0], n[1], n[1], n[2], n[2]};
            LEN_ARGB4:  argb = {n[0], n[0], n[1], n[1], n[2], n[2], n[3], n[3]};
            LEN_RGB6:   argb = {ALPHA_OPAQUE, n[0], n[1], n[2], n[3], n[4], n[5]};
            LEN_RGB9:   argb = {ALPHA_OPAQUE, n[0], n[1], n[3], n[4], n[6], n[7]};
            LEN_RGB12:  argb = {ALPHA_OPAQUE, n[0], n[1], n[4], n[5], n[8], n[9]};
            LEN_ARGB8:  argb = {n[0], n[1], n[2], n[3], n[4], n[5], n[6], n[7]};
            LEN_ARGB16: argb = {n[0], n[1], n[4], n[5], n[8], n[9], n[12], n[13]};
            default: begin
                argb      = '0;
                format_ok = 1'b0;
            end
        endcase
    end

endmodule

### rtl/hex_color_to_argb_parser_core.sv
// Top level of the hex color parser: input register, digit store, decoder, result register.
// Throughput: one character word per cycle, back to back, while no result word waits on m_*.
// A terminator's result is decoded from the input register into the result register on m_*.
// Characters that do not end a token ('#' lead-in, hex digits) produce no result word.
// The input register and the result register form two pipeline stages with full backpressure.
// Reset (aresetn low, synchronous) empties both stages and clears count and token state.
module hex_color_to_argb_parser_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [7:0]                    s_char_in,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [hcap_pkg::ARGB_W-1:0]   m_argb,
    output logic                          m_format_ok,
    output logic [hcap_pkg::COUNT_W-1:0]  m_digit_count
);
    import hcap_pkg::*;

    logic               in_valid_reg, in_valid_next;
    logic [7:0]         char_reg;
    logic               out_valid_reg, out_valid_next;
    logic [ARGB_W-1:0]  argb_reg;
    logic               ok_reg;
    logic [COUNT_W-1:0] count_out_reg;

    logic               advance;
    logic               step;
    hcap_tok_t          tok;
    nib_vec_t           nibbles;
    logic [ARGB_W-1:0]  dec_argb;
    logic               dec_ok;

    hcap_digit_store u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .char_in (char_reg),
        .tok     (tok),
        .nibbles (nibbles)
    );

    hcap_decode u_decode (
        .count     (tok.count),
        .nibbles   (nibbles),
        .argb      (dec_argb),
        .format_ok (dec_ok)
    );

    // The held word moves on whenever the result register is free or being drained.
    always_comb begin
        advance = !out_valid_reg || m_ready;
        s_ready = !in_valid_reg || advance;
        step    = in_valid_reg && advance;

        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = step && tok.term;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            char_reg <= s_char_in;
        end
        if (step && tok.term) begin
            argb_reg      <= dec_argb;
            ok_reg        <= dec_ok;
            count_out_reg <= tok.count;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_argb        = argb_reg;
    assign m_format_ok   = ok_reg;
    assign m_digit_count = count_out_reg;

endmodule

### rtl/hcap_checker.sv
// Port-level checks for the hex color parser, bound to the top level.
module hcap_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_valid,
    input logic                          s_ready,
    input logic [7:0]                    s_char_in,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic [hcap_pkg::ARGB_W-1:0]   m_argb,
    input logic                          m_format_ok,
    input logic [hcap_pkg::COUNT_W-1:0]  m_digit_count
);
    import hcap_pkg::*;

    // A stalled input word stays offered and unchanged until it is taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_char_in))
        else $error("input word changed while stalled");

    // A stalled result word must hold until it is taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_argb) && $stable(m_format_ok)
            && $stable(m_digit_count))
        else $error("result word changed while stalled");

    // The format flag must agree with the reported digit count.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_format_ok == (m_digit_count == LEN_RGB3 || m_digit_count == LEN_ARGB4
            || m_digit_count == LEN_RGB6 || m_digit_count == LEN_ARGB8
            || m_digit_count == LEN_RGB9 || m_digit_count == LEN_RGB12
            || m_digit_count == LEN_ARGB16)))
        else $error("format flag disagrees with digit count");

    // A rejected token carries a zero color, and the count never passes saturation.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_format_ok || m_argb == '0) && (m_digit_count <= COUNT_SAT))
        else $error("bad color or count on rejected token");

    // Nothing is presented in the cycle after reset.
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

endmodule

bind hex_color_to_argb_parser_core hcap_checker u_hcap_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .s_char_in     (s_char_in),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_argb        (m_argb),
    .m_format_ok   (m_format_ok),
    .m_digit_count (m_digit_count)
);

### verif/tb_hex_color_to_argb_parser_core.sv
// Self-checking testbench for the hex color to ARGB parser core.

// Classifies one ASCII byte as a hex digit and returns its nibble value.
function automatic bit hex_digit(input logic [7:0] ch, output logic [3:0] v);
    logic [7:0] d;
    d = 8'h00;
    v = 4'h0;
    if (ch >= "0" && ch <= "9") begin
        d = ch - "0";
    end else if (ch >= "a" && ch <= "f") begin
        d = ch - "a" + 8'd10;
    end else if (ch >= "A" && ch <= "F") begin
        d = ch - "A" + 8'd10;
    end else begin
        return 1'b0;
    end
    v = d[3:0];
    return 1'b1;
endfunction

typedef struct packed {
    logic [hcap_pkg::ARGB_W-1:0]  argb;
    logic                         ok;
    logic [hcap_pkg::COUNT_W-1:0] cnt;
} color_t;

class argb_checker;
    logic [3:0]                   nibbles [hcap_pkg::STORE_DEPTH];
    logic [hcap_pkg::COUNT_W-1:0] digit_cnt;
    bit                           in_token;
    color_t                       expected_colors [$];
    int                           errors;

    function new();
        foreach (nibbles[i]) nibbles[i] = 4'h0;
        digit_cnt = '0;
        in_token  = 1'b0;
        errors    = 0;
    endfunction

    function logic [7:0] byte_from(input int idx);
        return {nibbles[idx], nibbles[idx+1]};
    endfunction

    function color_t decode_token();
        color_t c;
        int     d;
        c.cnt = digit_cnt;
        c.ok  = 1'b1;
        d     = 0;
        case (digit_cnt)
            hcap_pkg::LEN_RGB3: begin
                c.argb = {hcap_pkg::ALPHA_OPAQUE, {2{nibbles[0]}}, {2{nibbles[1]}},
                          {2{nibbles[2]}}};
            end
            hcap_pkg::LEN_ARGB4: begin
                c.argb = {{2{nibbles[0]}}, {2{nibbles[1]}}, {2{nibbles[2]}},
                          {2{nibbles[3]}}};
            end
            hcap_pkg::LEN_RGB6, hcap_pkg::LEN_RGB9, hcap_pkg::LEN_RGB12: begin
                d      = int'(digit_cnt) / 3;
                c.argb = {hcap_pkg::ALPHA_OPAQUE, byte_from(0), byte_from(d),
                          byte_from(2*d)};
            end
            hcap_pkg::LEN_ARGB8, hcap_pkg::LEN_ARGB16: begin
                d      = int'(digit_cnt) / 4;
                c.argb = {byte_from(0), byte_from(d), byte_from(2*d), byte_from(3*d)};
            end
            default: begin
                c.argb = '0;
                c.ok   = 1'b0;
            end
        endcase
        return c;
    endfunction

    // Called for every accepted input word; a terminator queues one expected color.
    function void note_char(input logic [7:0] ch);
        logic [3:0] v;
        if (!in_token && ch == hcap_pkg::HASH_CHAR) begin
            in_token = 1'b1;
            return;
        end
        if (hex_digit(ch, v)) begin
            in_token = 1'b1;
            if (digit_cnt < hcap_pkg::COUNT_FULL) nibbles[digit_cnt[3:0]] = v;
            if (digit_cnt < hcap_pkg::COUNT_SAT) digit_cnt = digit_cnt + 1'b1;
            return;
        end
        expected_colors.push_back(decode_token());
        digit_cnt = '0;
        in_token  = 1'b0;
    endfunction

    function void check_color(input logic [hcap_pkg::ARGB_W-1:0] argb, input logic ok,
                              input logic [hcap_pkg::COUNT_W-1:0] cnt);
        color_t want;
        if (expected_colors.size() == 0) begin
            $display("%0t: unexpected result word argb %h ok %b count %0d",
                     $time, argb, ok, cnt);
            errors++;
            return;
        end
        want = expected_colors.pop_front();
        if (want.argb !== argb) begin
            $display("%0t: argb expected %h actual %h", $time, want.argb, argb);
            errors++;
        end
        if (want.ok !== ok) begin
            $display("%0t: format_ok expected %b actual %b", $time, want.ok, ok);
            errors++;
        end
        if (want.cnt !== cnt) begin
            $display("%0t: digit_count expected %0d actual %0d", $time, want.cnt, cnt);
            errors++;
        end
    endfunction
endclass

module tb_hex_color_to_argb_parser_core;
    logic                          aclk;
    logic                          aresetn;
    logic                          s_valid;
    logic                          s_ready;
    logic [7:0]                    s_char_in;
    logic                          m_valid;
    logic                          m_ready;
    logic [hcap_pkg::ARGB_W-1:0]   m_argb;
    logic                          m_format_ok;
    logic [hcap_pkg::COUNT_W-1:0]  m_digit_count;

    argb_checker sb;
    int          src_idle_pct;
    int          sink_idle_pct;
    bit          hold_req;
    int          hold_left;
    int          chars_sent;
    int          fmt_lens [7] = '{3, 4, 6, 8, 9, 12, 16};

    hex_color_to_argb_parser_core i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_char_in     (s_char_in),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_argb        (m_argb),
        .m_format_ok   (m_format_ok),
        .m_digit_count (m_digit_count)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #2000000;
        $display("tb_hex_color_to_argb_parser_core: errors");
        $finish;
    end

    // Receiver side: random stalls, plus a long hold-off counted here on request.
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            hold_left--;
            m_ready = 1'b0;
        end else if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = 63;
            m_ready   = 1'b0;
        end else begin
            m_ready = ($urandom_range(99) >= sink_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_color(m_argb, m_format_ok, m_digit_count);
    end

    task automatic send_char(input logic [7:0] ch);
        @(negedge aclk);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid   = 1'b0;
            s_char_in = 8'($urandom);
            @(negedge aclk);
        end
        s_valid   = 1'b1;
        s_char_in = ch;
        do @(posedge aclk); while (!s_ready);
        sb.note_char(ch);
        chars_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_char(s[i]);
    endtask

    function automatic logic [7:0] digit_char(input logic [3:0] v);
        if (v < 4'd10) return 8'h30 + v;
        return ($urandom_range(1) ? 8'h61 : 8'h41) + v - 8'd10;
    endfunction

    function automatic logic [7:0] random_terminator();
        logic [7:0] c;
        logic [3:0] v;
        do c = 8'($urandom_range(255)); while (hex_digit(c, v));
        return c;
    endfunction

    // Mostly well-formed tokens with random content, the rest odd lengths and raw noise.
    task automatic send_token();
        int kind;
        int len;
        kind = $urandom_range(99);
        if (kind < 10) begin
            repeat ($urandom_range(1, 4)) send_char(8'($urandom_range(255)));
            return;
        end
        if ($urandom_range(1)) send_char(hcap_pkg::HASH_CHAR);
        if (kind < 78) len = fmt_lens[$urandom_range(6)];
        else len = $urandom_range(20);
        repeat (len) send_char(digit_char(4'($urandom_range(15))));
        send_char(random_terminator());
    endtask

    initial begin
        sb            = new();
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_char_in     = 8'h00;
        m_ready       = 1'b0;
        hold_req      = 1'b0;
        hold_left     = 0;
        chars_sent    = 0;
        src_idle_pct  = 38;
        sink_idle_pct = 79;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed: three- and four-digit short forms, lone and repeated hash, edge bytes.
        send_text("#fFa");
        send_char(8'h00);
        send_text("09AF");
        send_char(8'hff);
        send_text("##");
        send_text("/");
        send_text("1:");
        send_text("@");
        send_text("G");
        send_char(8'h60);
        send_text("g");
        send_text("#5");
        send_char(8'h80);

        while (chars_sent < 370) send_token();
        src_idle_pct  = 79;
        sink_idle_pct = 38;
        while (chars_sent < 720) send_token();
        src_idle_pct  = 0;
        sink_idle_pct = 0;

        // Back up the result path while a run of terminators keeps arriving.
        hold_req = 1'b1;
        repeat (12) send_char(8'h3b);
        while (chars_sent < 1050) send_token();

        @(negedge aclk);
        s_valid = 1'b0;
        while (sb.expected_colors.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("tb_hex_color_to_argb_parser_core: clean");
        end else begin
            $display("tb_hex_color_to_argb_parser_core: errors");
        end
        $finish;
    end
endmodule
